// File: hdl/lccb_pkg.sv
package lccb_pkg;

   // card number field and packed stream widths
   localparam int CARD_W      = 63;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 8;
   localparam int COUNT_W     = 5;
   localparam int BRAND_W     = 2;

   // binary to BCD conversion: padded binary word, bits shifted in per cycle
   localparam int BIN_W       = 64;
   localparam int BITS_PER_CYC = 4;
   localparam int CONV_CYCLES = BIN_W / BITS_PER_CYC;
   localparam int CONV_CNT_W  = $clog2(CONV_CYCLES);
   localparam int BCD_DIGITS  = 19;
   localparam int BCD_W       = 4 * BCD_DIGITS;

   // brand codes
   localparam logic [BRAND_W-1:0] BRAND_NONE = 2'd0;
   localparam logic [BRAND_W-1:0] BRAND_AX   = 2'd1;
   localparam logic [BRAND_W-1:0] BRAND_MC   = 2'd2;
   localparam logic [BRAND_W-1:0] BRAND_VI   = 2'd3;

   // card lengths that carry a brand
   localparam logic [COUNT_W-1:0] LEN_AX    = 5'd15;
   localparam logic [COUNT_W-1:0] LEN_MC    = 5'd16;
   localparam logic [COUNT_W-1:0] LEN_VI_S  = 5'd13;

endpackage

// File: hdl/luhn_card_check_and_brand.sv
// Luhn mod-10 card number check with brand lookup from the leading digits.
//
// Input channel (req_*): one transfer carries one card number as an unsigned
// 63-bit binary integer. The block takes a new number only when it is idle;
// req_tready is low for the whole time one number is being worked on.
// Result channel (rsp_*): one transfer per card number with the Luhn verdict,
// the decimal digit count (zero counts as one digit) and the brand code.
//
// Flow: after an input transfer the number is turned into BCD, four binary
// bits a cycle through one add-3/shift column. A digit scanner then walks the
// BCD digits from the right, one per cycle, until only zero digits are left
// or MAX_DIGITS digits have been read. A classify step then loads the result
// register and the block goes back to idle, ready for a new input; it takes
// no new number while one is still being worked on. The result sits in an
// output register. If the receiver stalls, the block still goes back to idle
// and takes the next number; it only waits at the final classify step until
// the previous result has been taken.
// Reset (synchronous, active high) drops any item in flight and any held
// result and returns the block to idle.
module luhn_card_check_and_brand
   import lccb_pkg::*;
#(
   parameter int MAX_DIGITS = 19
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [62:0] card_number, [63] zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [0] luhn_ok, [5:1] digit_count, [7:6] brand
);

   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_DIGITS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CONV,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type                 state_ff, state_in;
   logic [BIN_W-1:0]          bin_ff, bin_in;         // binary bits still to shift in
   logic [BCD_W-1:0]          bcd_ff, bcd_in;         // BCD digits, lowest digit at bit 0
   logic [CONV_CNT_W-1:0]     conv_cnt_ff, conv_cnt_in;
   logic [COUNT_W-1:0]        count_ff, count_in;     // digits consumed so far
   logic [3:0]                sum_ff, sum_in;         // Luhn sum modulo ten
   logic [3:0]                lead_hi_ff, lead_hi_in; // most recent digit seen
   logic [3:0]                lead_lo_ff, lead_lo_in; // digit before it
   logic                      over_ff, over_in;       // digits left past MAX_DIGITS
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   // shared add-3/shift column result for one conversion cycle
   logic [BCD_W-1:0]          dabble;
   // digit scanner
   logic [3:0]                digit;
   logic [4:0]                dbl;
   logic [3:0]                contrib;
   logic [4:0]                sum_raw;
   logic [COUNT_W-1:0]        count_next;
   logic [BCD_W-1:0]          bcd_rest;
   // classification
   logic                      luhn_ok;
   logic [BRAND_W-1:0]        brand;
   logic                      out_free;

   // double dabble: four bits a cycle, each bit an add-3 pass over all digits
   always_comb begin
      logic [BCD_W-1:0] b;
      b = bcd_ff;
      for (int k = 0; k < BITS_PER_CYC; k++) begin
         for (int j = 0; j < BCD_DIGITS; j++) begin
            if (b[4*j +: 4] >= 4'd5) begin
               b[4*j +: 4] = b[4*j +: 4] + 4'd3;
            end
         end
         b = {b[BCD_W-2:0], bin_ff[BIN_W-1-k]};
      end
      dabble = b;
   end

   // Luhn contribution of the current lowest digit
   always_comb begin
      digit   = bcd_ff[3:0];
      dbl     = {digit, 1'b0};
      if (count_ff[0]) begin
         contrib = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
      end else begin
         contrib = digit;
      end
      sum_raw    = {1'b0, sum_ff} + {1'b0, contrib};
      count_next = count_ff + 5'd1;
      bcd_rest   = {4'd0, bcd_ff[BCD_W-1:4]};
   end

   // Luhn verdict, and brand from digit count and leading pair (none on a failed check)
   always_comb begin
      luhn_ok = !over_ff && (sum_ff == 4'd0);
      brand   = BRAND_NONE;
      if (count_ff == LEN_AX && lead_hi_ff == 4'd3 &&
          (lead_lo_ff == 4'd4 || lead_lo_ff == 4'd7)) begin
         brand = BRAND_AX;
      end else if (count_ff == LEN_MC && lead_hi_ff == 4'd5 &&
                   lead_lo_ff >= 4'd1 && lead_lo_ff <= 4'd5) begin
         brand = BRAND_MC;
      end else if ((count_ff == LEN_VI_S || count_ff == LEN_MC) &&
                   lead_hi_ff == 4'd4) begin
         brand = BRAND_VI;
      end
      if (!luhn_ok) begin
         brand = BRAND_NONE;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      conv_cnt_in  = conv_cnt_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      lead_hi_in   = lead_hi_ff;
      lead_lo_in   = lead_lo_ff;
      over_in      = over_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               bin_in      = {1'b0, req_tdata[CARD_W-1:0]};
               bcd_in      = '0;
               conv_cnt_in = '0;
               state_in    = S_CONV;
            end
         end
         S_CONV: begin
            bcd_in      = dabble;
            bin_in      = {bin_ff[BIN_W-BITS_PER_CYC-1:0], {BITS_PER_CYC{1'b0}}};
            conv_cnt_in = conv_cnt_ff + CONV_CNT_W'(1);
            if (conv_cnt_ff == CONV_CNT_W'(CONV_CYCLES - 1)) begin
               count_in   = '0;
               sum_in     = '0;
               lead_hi_in = '0;
               lead_lo_in = '0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            bcd_in     = bcd_rest;
            count_in   = count_next;
            sum_in     = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
            lead_hi_in = digit;
            lead_lo_in = lead_hi_ff;
            over_in    = (bcd_rest != '0);
            // stop once the rest is all zero, or the digit budget is used up
            if (bcd_rest == '0 || count_next == MAX_CNT) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {brand, count_ff, luhn_ok};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      conv_cnt_ff <= conv_cnt_in;
      count_ff    <= count_in;
      sum_ff      <= sum_in;
      lead_hi_ff  <= lead_hi_in;
      lead_lo_ff  <= lead_lo_in;
      over_ff     <= over_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // a branded result always passed the Luhn check
   a_brand_needs_luhn: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:6] == BRAND_NONE || rsp_tdata[0]))
      else $error("brand set on a result that failed the Luhn check");

   // digit count stays within one to MAX_DIGITS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5:1] != 5'd0 && rsp_tdata[5:1] <= MAX_CNT))
      else $error("digit count out of range");

   // a brand only goes with one of the branded lengths
   a_brand_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[7:6] != BRAND_NONE) |->
         (rsp_tdata[5:1] == LEN_AX || rsp_tdata[5:1] == LEN_MC ||
          rsp_tdata[5:1] == LEN_VI_S))
      else $error("brand reported for a length that carries none");

   // an accepted number always starts conversion on the next cycle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_CONV && conv_cnt_ff == '0))
      else $error("input transfer did not start conversion");
`endif

endmodule
